@@ rtl/ctlpc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctlpc_pkg - shared definitions for the control pin conditioner
// Widths, command and pin type codes, register indexes and the structs that
// travel between the conditioner's stages.
// ----------------------------------------------------------------------------
`default_nettype none

package ctlpc_pkg;

   localparam int PIN_COUNT    = 16;
   localparam int PIN_W        = 4;
   localparam int DATA_W       = 16;
   localparam int KIND_W       = 3;
   localparam int PIN_TYPES_W  = 48;
   localparam int CMD_W        = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int FILTER_SHIFT = 6;

   localparam logic [DATA_W-1:0] ON_VALUE       = 16'd127;
   localparam logic [DATA_W-1:0] DEBOUNCE_RESET = 16'd8192;
   localparam logic [DATA_W-1:0] BLINK_RESET    = 16'd100;

   typedef enum logic [CMD_W-1:0] {
      CMD_PROCESS = 2'd0,
      CMD_WRITE   = 2'd1,
      CMD_READ    = 2'd2
   } cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_UNUSED = 3'd0,
      KIND_KNOB   = 3'd1,
      KIND_BUTTON = 3'd2,
      KIND_LED    = 3'd3,
      KIND_BLINK  = 3'd4
   } pin_kind_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIN_TYPES    = 2'd0,
      CSR_PRESS_TARGET = 2'd1,
      CSR_FLASH_STEPS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PIN_TYPES_W-1:0] pin_types;
      logic [DATA_W-1:0]      press_target;
      logic [DATA_W-1:0]      flash_steps;
   } cfg_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [PIN_W-1:0]  pin;
      logic [DATA_W-1:0] analog_sample;
      logic              digital_level;
      logic [DATA_W-1:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic [PIN_W-1:0]  pin_echo;
      logic [DATA_W-1:0] read_value;
      logic              drive_level;
      logic              drive_valid;
   } rsp_item_type;

endpackage

`default_nettype wire

@@ rtl/ctlpc_csr.sv @@
// ----------------------------------------------------------------------------
// ctlpc_csr - configuration registers
// Holds the packed pin type word, the button debounce target and the blink
// duration, written through the plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlpc_csr
   import ctlpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PIN_TYPES_W-1:0] csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_PIN_TYPES:    cfg_in.pin_types    = csr_wdata;
            CSR_PRESS_TARGET: cfg_in.press_target = csr_wdata[DATA_W-1:0];
            CSR_FLASH_STEPS:  cfg_in.flash_steps  = csr_wdata[DATA_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pin_types    <= '0;
         cfg_ff.press_target <= DEBOUNCE_RESET;
         cfg_ff.flash_steps  <= BLINK_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/ctlpc_req_reg.sv @@
// ----------------------------------------------------------------------------
// ctlpc_req_reg - request register
// Captures one request transaction and holds it until the result stage can
// take it; refills in the same cycle it hands over.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlpc_req_reg
   import ctlpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   input  logic         can_take,
   output logic         fire,
   output req_item_type item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         accept;

   assign req_stall = valid_ff && !can_take;
   assign accept    = req_valid && !req_stall;
   assign fire      = valid_ff && can_take;

   always_comb begin
      valid_in = valid_ff;
      if (accept) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item = item_ff;

endmodule

`default_nettype wire

@@ rtl/ctlpc_pin_unit.sv @@
// ----------------------------------------------------------------------------
// ctlpc_pin_unit - per-pin state and conditioning logic
// Level and auxiliary register files with one read-modify-write per
// transaction: knob and button filters, led toggle, blink countdown, writes
// and reads.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlpc_pin_unit
   import ctlpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  req_item_type item,
   input  logic         fire,
   output rsp_item_type result
);

   logic [DATA_W-1:0] level_ff [PIN_COUNT];
   logic [DATA_W-1:0] aux_ff [PIN_COUNT];

   logic [DATA_W-1:0] level_in;
   logic [DATA_W-1:0] aux_in;
   logic              level_we;
   logic              aux_we;
   logic [DATA_W-1:0] lvl;
   logic [DATA_W-1:0] aux;
   logic [KIND_W-1:0] kind_bits;
   logic [DATA_W-1:0] target;
   logic [DATA_W-1:0] read_data;
   logic              drive;
   logic              drive_ok;
   logic              in_range;

   // signed step toward target, magnitude of the difference shifted down
   function automatic logic [DATA_W-1:0] scaled_step(input logic [DATA_W-1:0] tgt,
                                                     input logic [DATA_W-1:0] ref_lvl);
      logic [DATA_W-1:0] diff;
      begin
         if (tgt >= ref_lvl) begin
            diff        = tgt - ref_lvl;
            scaled_step = diff >> FILTER_SHIFT;
         end else begin
            diff        = ref_lvl - tgt;
            scaled_step = '0 - (diff >> FILTER_SHIFT);
         end
      end
   endfunction

   assign in_range  = ({1'b0, item.pin} < (PIN_W + 1)'(PIN_COUNT));
   assign lvl       = level_ff[item.pin];
   assign aux       = aux_ff[item.pin];
   assign kind_bits = cfg.pin_types[item.pin * KIND_W +: KIND_W];

   always_comb begin
      level_in  = lvl;
      aux_in    = aux;
      level_we  = 1'b0;
      aux_we    = 1'b0;
      read_data = '0;
      drive     = 1'b0;
      drive_ok  = 1'b0;
      target    = item.analog_sample;
      if (in_range) begin
         case (cmd_type'(item.cmd))
            CMD_PROCESS: begin
               case (pin_kind_type'(kind_bits))
                  KIND_KNOB, KIND_BUTTON: begin
                     if (pin_kind_type'(kind_bits) == KIND_BUTTON) begin
                        target = item.digital_level ? cfg.press_target : '0;
                     end
                     aux_in   = aux + scaled_step(target, lvl);
                     level_in = aux_in;
                     aux_we   = 1'b1;
                     level_we = 1'b1;
                  end
                  KIND_LED: begin
                     if (lvl != '0) begin
                        aux_in = (aux == '0) ? DATA_W'(1) : '0;
                     end else begin
                        aux_in = '0;
                     end
                     aux_we   = 1'b1;
                     drive    = aux_in[0];
                     drive_ok = 1'b1;
                  end
                  KIND_BLINK: begin
                     if (lvl != '0) begin
                        drive    = 1'b1;
                        level_in = lvl - DATA_W'(1);
                        level_we = 1'b1;
                     end
                     drive_ok = 1'b1;
                  end
                  default: begin
                     level_we = 1'b0;
                  end
               endcase
            end
            CMD_WRITE: begin
               case (pin_kind_type'(kind_bits))
                  KIND_LED: begin
                     level_in = item.write_value;
                     level_we = 1'b1;
                  end
                  KIND_BLINK: begin
                     level_in = (item.write_value != '0) ? cfg.flash_steps : '0;
                     level_we = 1'b1;
                  end
                  default: begin
                     level_we = 1'b0;
                  end
               endcase
            end
            CMD_READ: begin
               case (pin_kind_type'(kind_bits))
                  KIND_KNOB: begin
                     read_data = lvl;
                  end
                  KIND_BUTTON: begin
                     read_data = (lvl > (cfg.press_target >> 1)) ? ON_VALUE : '0;
                  end
                  KIND_LED, KIND_BLINK: begin
                     read_data = (lvl != '0) ? ON_VALUE : '0;
                  end
                  default: begin
                     read_data = '0;
                  end
               endcase
            end
            default: begin
               read_data = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIN_COUNT; i++) begin
            level_ff[i] <= '0;
            aux_ff[i]   <= '0;
         end
      end else if (fire) begin
         if (level_we) begin
            level_ff[item.pin] <= level_in;
         end
         if (aux_we) begin
            aux_ff[item.pin] <= aux_in;
         end
      end
   end

   assign result.pin_echo    = item.pin;
   assign result.read_value  = read_data;
   assign result.drive_level = drive;
   assign result.drive_valid = drive_ok;

endmodule

`default_nettype wire

@@ rtl/ctlpc_rsp_reg.sv @@
// ----------------------------------------------------------------------------
// ctlpc_rsp_reg - result register
// Holds one result transaction until the receiver takes it, and tells the
// request side when a new result can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlpc_rsp_reg
   import ctlpc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         fire,
   input  rsp_item_type result,
   input  logic         rsp_stall,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   output logic         can_take
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type item_ff;

   assign can_take = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (fire) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

`default_nettype wire

@@ rtl/control_pin_conditioner.sv @@
// ----------------------------------------------------------------------------
// control_pin_conditioner - per-pin conditioning for a bank of panel pins
// Top level: configuration registers, request register, pin unit and result
// register.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle unless a stalled result holds the
// request register, and each gives exactly one result. A request is held in
// the request register while a single read-modify-write of the per-pin level
// and auxiliary register files works out its result, which is then loaded
// into the result register. A stalled result holds the request register, and
// back-to-back transactions to the same pin see each other's updates. The user
// must write configuration through the csr port only while no transaction is
// in flight; the block itself does not enforce this.
`default_nettype none

module control_pin_conditioner
   import ctlpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [PIN_TYPES_W-1:0] csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [PIN_W-1:0]       req_pin,
   input  logic [DATA_W-1:0]      req_analog_sample,
   input  logic                   req_digital_level,
   input  logic [DATA_W-1:0]      req_write_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [PIN_W-1:0]       rsp_pin_echo,
   output logic [DATA_W-1:0]      rsp_read_value,
   output logic                   rsp_drive_level,
   output logic                   rsp_drive_valid
);

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   rsp_item_type result;
   rsp_item_type rsp_item;
   logic         fire;
   logic         can_take;

   assign req_item.cmd           = req_cmd;
   assign req_item.pin           = req_pin;
   assign req_item.analog_sample = req_analog_sample;
   assign req_item.digital_level = req_digital_level;
   assign req_item.write_value   = req_write_value;

   ctlpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .cfg              (cfg)
   );

   ctlpc_req_reg u_req_reg (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .can_take  (can_take),
      .fire      (fire),
      .item      (item)
   );

   ctlpc_pin_unit u_pin_unit (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (item),
      .fire   (fire),
      .result (result)
   );

   ctlpc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .result    (result),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .can_take  (can_take)
   );

   assign rsp_pin_echo    = rsp_item.pin_echo;
   assign rsp_read_value  = rsp_item.read_value;
   assign rsp_drive_level = rsp_item.drive_level;
   assign rsp_drive_valid = rsp_item.drive_valid;

endmodule

`default_nettype wire

@@ rtl/ctlpc_checker.sv @@
// ----------------------------------------------------------------------------
// ctlpc_checker - port-level checks for the control pin conditioner
// Watches the top level's ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
`default_nettype none

module ctlpc_checker
   import ctlpc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [PIN_W-1:0]  rsp_pin_echo,
   input logic [DATA_W-1:0] rsp_read_value,
   input logic              rsp_drive_level,
   input logic              rsp_drive_valid
);

   // nothing in flight straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result or stall present after reset");

   // an empty result register never back-pressures the request side
   a_no_stall_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty result register");

   // drive level only accompanies a driving process step
   a_drive_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_valid |-> !rsp_drive_level)
      else $error("drive level set without drive valid");

   // reads and drive steps come from different commands
   a_read_no_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_read_value != '0) |-> !rsp_drive_valid)
      else $error("read value and drive valid in one transaction");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pin_echo)
         && $stable(rsp_read_value) && $stable(rsp_drive_level)
         && $stable(rsp_drive_valid))
      else $error("stalled result transaction changed");

endmodule

bind control_pin_conditioner ctlpc_checker u_ctlpc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_pin_echo    (rsp_pin_echo),
   .rsp_read_value  (rsp_read_value),
   .rsp_drive_level (rsp_drive_level),
   .rsp_drive_valid (rsp_drive_valid)
);

`default_nettype wire
